// ----- hw/rtl/afsg_pkg.sv -----
`timescale 1ns / 1ps
// Package for the affine fractal segment generator.
// Widths, fixed-point constants and saturation helpers; no dependencies.
package afsg_pkg;

  localparam int unsigned MaxRules   = 256;
  localparam int unsigned MaxDepth   = 15;
  localparam int unsigned SeedPoints = 7;

  localparam int unsigned QW      = 20;  // Q3.16 word
  localparam int unsigned PxW     = 16;
  localparam int unsigned RuleAw  = $clog2(MaxRules);
  localparam int unsigned DepthW  = $clog2(MaxDepth + 1);
  localparam int unsigned CountW  = $clog2(MaxRules + 1);
  localparam int unsigned PtAw    = $clog2(SeedPoints);
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 18;

  localparam logic [0:0] OpLoad = 1'b0;
  localparam logic [0:0] OpStep = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegPlotWidth   = 8'd0,
    RegPlotHeight  = 8'd1,
    RegBorder      = 8'd2,
    RegSeedWidth   = 8'd3,
    RegSeedHeight  = 8'd4,
    RegRuleCount   = 8'd5,
    RegDepthLevels = 8'd6,
    RegDrawL       = 8'd7
  } cfg_reg_e;

  typedef logic signed [QW-1:0]  q_t;
  typedef logic signed [PxW-1:0] px_t;

  typedef struct packed {
    q_t a;
    q_t b;
    q_t c;
    q_t d;
    q_t e;
    q_t f;
  } rule_t;

  typedef struct packed {
    q_t x;
    q_t y;
  } point_t;

  function automatic q_t sat20(input logic signed [26:0] v);
    if (v > 27'sd524287) return 20'sd524287;
    else if (v < -27'sd524288) return -20'sd524288;
    else return v[19:0];
  endfunction

  function automatic px_t sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) return 16'sd32767;
    else if (v < -22'sd32768) return -16'sd32768;
    else return v[15:0];
  endfunction

endpackage

// ----- hw/rtl/afsg_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on afsg_pkg.
interface afsg_in_if;
  logic                            valid;
  logic                            ready;
  logic                            op;
  logic [afsg_pkg::RuleAw-1:0]     rule_index;
  afsg_pkg::q_t                    coef_a;
  afsg_pkg::q_t                    coef_b;
  afsg_pkg::q_t                    coef_c;
  afsg_pkg::q_t                    coef_d;
  afsg_pkg::q_t                    coef_e;
  afsg_pkg::q_t                    coef_f;
  modport source (output valid, op, rule_index, coef_a, coef_b, coef_c, coef_d, coef_e,
                  coef_f, input ready);
  modport sink   (input valid, op, rule_index, coef_a, coef_b, coef_c, coef_d, coef_e,
                  coef_f, output ready);
endinterface

interface afsg_out_if;
  logic          valid;
  logic          ready;
  afsg_pkg::px_t x_start;
  afsg_pkg::px_t y_start;
  afsg_pkg::px_t x_end;
  afsg_pkg::px_t y_end;
  logic          segment_kind;
  logic          is_last;
  logic          done_res;
  modport source (output valid, x_start, y_start, x_end, y_end, segment_kind, is_last,
                  done_res, input ready);
  modport sink   (input valid, x_start, y_start, x_end, y_end, segment_kind, is_last,
                  done_res, output ready);
endinterface

interface afsg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [afsg_pkg::CfgIdxW-1:0]  index;
  logic [afsg_pkg::CfgDatW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/affine_fractal_segment_generator.sv -----
`timescale 1ns / 1ps
// Top level of the affine fractal segment generator.
// Depends on afsg_pkg and the channel interfaces in afsg_if.sv.
//
// Usage:
//  cfg_i  : register writes (index, data), always ready; write only while idle.
//  in_i   : requests. op=load stores one rule in the rule table and restarts
//           the walk (no result). op=step yields the next leaf's segments:
//           four box edges, plus two L strokes when RegDrawL is set, the
//           final one flagged is_last. After the last leaf a step yields one
//           done result (zero coordinates, is_last=1, done_res=1).
//  out_o  : results, one output register.
// Sequence: a step advances the path odometer (not on the first step of a
// walk), writes the seed points, applies each level's rule to every point
// and converts both ends of each segment to pixels. Cost is set by the
// single read port of the point memory: each point is read, multiplied and
// written back per level, and each segment end is read and scaled on its own.
// Reset clears the walk state and loads the register defaults; the rule table
// is not cleared. A stalled receiver holds the output register; the block
// stops at the next result until it drains and accepts a new request once
// the last result of a step sits in the output register.
module affine_fractal_segment_generator (
  input logic clk_i,
  input logic rst_ni,
  afsg_cfg_if.sink   cfg_i,
  afsg_in_if.sink    in_i,
  afsg_out_if.source out_o
);
  import afsg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADV  = 4'd1;
  localparam logic [3:0] S_SEED = 4'd2;
  localparam logic [3:0] S_RULE = 4'd3;
  localparam logic [3:0] S_PRD  = 4'd4;
  localparam logic [3:0] S_PMUL = 4'd5;
  localparam logic [3:0] S_PWR  = 4'd6;
  localparam logic [3:0] S_ERD  = 4'd7;
  localparam logic [3:0] S_EMUL = 4'd8;
  localparam logic [3:0] S_ECV  = 4'd9;
  localparam logic [3:0] S_EOUT = 4'd10;

  // configuration
  logic [12:0] width_q, height_q;
  logic [10:0] border_q;
  logic [17:0] seed_w_q, seed_h_q;
  logic [8:0]  rcount_q;
  logic [3:0]  depth_q;
  logic        draw_l_q;

  logic [3:0]        state_q;
  logic              started_q, finished_q;
  logic [7:0]        path_q [MaxDepth];
  logic [DepthW-1:0] idx_q, lv_q;
  logic [PtAw-1:0]   k_q;
  logic [2:0]        seg_cnt_q;
  logic              half_q;

  rule_t  rule_mem [MaxRules];
  rule_t  rule_rd_q;
  point_t pt_mem [SeedPoints];
  point_t pt_rd_q;

  logic [PtAw-1:0] pt_raddr, pt_waddr;
  point_t          pt_wdata;
  logic            pt_we;
  logic [7:0]      rule_raddr;

  logic signed [39:0] pax_q, pby_q, pcx_q, pdy_q;
  logic signed [34:0] mx_q, my_q;
  px_t  xs_q, ys_q, xe_q, ye_q;

  logic out_valid_q;
  px_t  o_xs_q, o_ys_q, o_xe_q, o_ye_q;
  logic o_kind_q, o_last_q, o_done_q;
  logic st_done_q;

  logic       in_acc, out_free;
  logic [8:0] count_eff;
  logic [2:0] seg_n;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign count_eff   = (rcount_q > 9'(MaxRules)) ? 9'(MaxRules) : rcount_q;
  assign seg_n       = draw_l_q ? 3'd6 : 3'd4;

  // seed points from the seed box size
  function automatic point_t seed_pt(input logic [PtAw-1:0] k,
                                     input logic [17:0] bw, input logic [17:0] bh);
    logic signed [21:0] one, bws, bhs, xr, xl, yb, yt, t;
    logic [31:0] tp;
    q_t p0y, p1x, p2y, p4y, p5x;
    point_t r;
    one = 22'sd65536;
    bws = $signed({4'b0, bw});
    bhs = $signed({4'b0, bh});
    xr  = (one + bws) >>> 1;
    xl  = (one - bws) >>> 1;
    yb  = (one - bhs) >>> 1;
    yt  = (one + bhs) >>> 1;
    tp  = 32'(bh) * 32'd6554 + 32'd32768;
    t   = $signed({6'b0, tp[31:16]});
    p0y = sat20(27'(yb));
    p1x = sat20(27'(xl));
    p2y = sat20(27'(yt));
    p4y = sat20(27'(p0y) + 27'(t));
    p5x = sat20(27'(p1x) + 27'(t));
    unique case (k)
      3'd0:    r = '{x: sat20(27'(xr)), y: p0y};
      3'd1:    r = '{x: p1x, y: p0y};
      3'd2:    r = '{x: p1x, y: p2y};
      3'd3:    r = '{x: sat20(27'(xr)), y: p2y};
      3'd4:    r = '{x: 20'sd32768, y: p4y};
      3'd5:    r = '{x: p5x, y: p4y};
      3'd6:    r = '{x: p5x, y: sat20(27'(p2y) - 27'(t))};
      default: r = '0;
    endcase
    return r;
  endfunction

  // plot geometry
  logic [12:0]        side_min;
  logic signed [14:0] box, sc, xdiff, ydiff;
  logic [13:0]        xoff, yoff;
  assign side_min = (width_q < height_q) ? width_q : height_q;
  assign box   = $signed({2'b0, side_min}) - $signed({3'b0, border_q, 1'b0});
  assign sc    = box - 15'sd1;
  assign xdiff = $signed({2'b0, width_q}) - box;
  assign ydiff = $signed({2'b0, height_q}) - box;
  assign xoff  = 14'(xdiff >>> 1);
  assign yoff  = 14'(ydiff >>> 1);

  // segment endpoints: box edges wrap, L strokes run 4-5 and 5-6
  logic [PtAw-1:0] seg_q;
  assign seg_q = (seg_cnt_q == 3'd3) ? 3'd0 : seg_cnt_q + 3'd1;

  // pixel conversion
  logic signed [36:0] sx37, sy37;
  logic signed [20:0] pxx, pxy;
  px_t                col, row;
  assign sx37 = 37'(mx_q) + $signed({7'b0, xoff, 16'b0}) + 37'sd32768;
  assign sy37 = 37'(my_q) + $signed({7'b0, yoff, 16'b0}) + 37'sd32768;
  assign pxx  = 21'(sx37 >>> 16);
  assign pxy  = 21'(sy37 >>> 16);
  assign col  = sat16(22'(pxx));
  assign row  = sat16($signed({9'b0, height_q}) - 22'(pxy));

  // affine update
  logic signed [41:0] tx, ty;
  q_t                 nx, ny;
  assign tx = 42'(pax_q) + 42'(pby_q) + 42'sd32768;
  assign ty = 42'(pcx_q) + 42'(pdy_q) + 42'sd32768;
  assign nx = sat20(27'(tx >>> 16) + 27'(rule_rd_q.e));
  assign ny = sat20(27'(ty >>> 16) + 27'(rule_rd_q.f));

  // memory ports
  assign rule_raddr = path_q[4'(lv_q - 4'd1)];
  always_comb begin
    pt_raddr = k_q;
    if (state_q == S_ERD || state_q == S_EMUL || state_q == S_ECV)
      pt_raddr = half_q ? seg_q : seg_cnt_q;
    pt_we    = 1'b0;
    pt_waddr = k_q;
    pt_wdata = '{x: nx, y: ny};
    if (state_q == S_SEED) begin
      pt_we    = 1'b1;
      pt_wdata = seed_pt(k_q, seed_w_q, seed_h_q);
    end else if (state_q == S_PWR) begin
      pt_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.op == OpLoad)
      rule_mem[in_i.rule_index] <= '{a: in_i.coef_a, b: in_i.coef_b, c: in_i.coef_c,
                                     d: in_i.coef_d, e: in_i.coef_e, f: in_i.coef_f};
    rule_rd_q <= rule_mem[rule_raddr];
    if (pt_we)
      pt_mem[pt_waddr] <= pt_wdata;
    pt_rd_q <= pt_mem[pt_raddr];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_PMUL) begin
      pax_q <= rule_rd_q.a * pt_rd_q.x;
      pby_q <= rule_rd_q.b * pt_rd_q.y;
      pcx_q <= rule_rd_q.c * pt_rd_q.x;
      pdy_q <= rule_rd_q.d * pt_rd_q.y;
    end
    if (state_q == S_EMUL) begin
      mx_q <= pt_rd_q.x * sc;
      my_q <= pt_rd_q.y * sc;
    end
    if (state_q == S_ECV) begin
      if (half_q) begin
        xe_q <= col;
        ye_q <= row;
      end else begin
        xs_q <= col;
        ys_q <= row;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      border_q <= 11'd10;
      seed_w_q <= 18'd65536;
      seed_h_q <= 18'd65536;
      rcount_q <= 9'd1;
      depth_q  <= 4'd5;
      draw_l_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        RegPlotWidth:   width_q  <= cfg_i.data[12:0];
        RegPlotHeight:  height_q <= cfg_i.data[12:0];
        RegBorder:      border_q <= cfg_i.data[10:0];
        RegSeedWidth:   seed_w_q <= cfg_i.data;
        RegSeedHeight:  seed_h_q <= cfg_i.data;
        RegRuleCount:   rcount_q <= cfg_i.data[8:0];
        RegDepthLevels: depth_q  <= cfg_i.data[3:0];
        RegDrawL:       draw_l_q <= cfg_i.data[0];
        default:        ;
      endcase
    end
  end

  // sequencer
  logic [8:0] adv_p;
  assign adv_p = {1'b0, path_q[4'(idx_q - 4'd1)]} + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      for (int i = 0; i < MaxDepth; i++) path_q[i] <= '0;
      idx_q       <= '0;
      lv_q        <= '0;
      k_q         <= '0;
      seg_cnt_q   <= '0;
      half_q      <= 1'b0;
      st_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
      o_xs_q <= '0; o_ys_q <= '0; o_xe_q <= '0; o_ye_q <= '0;
      o_kind_q <= 1'b0; o_last_q <= 1'b0; o_done_q <= 1'b0;
    end else begin
      if (state_q == S_EOUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            k_q       <= '0;
            seg_cnt_q <= '0;
            half_q    <= 1'b0;
            if (in_i.op == OpLoad) begin
              started_q  <= 1'b0;
              finished_q <= 1'b0;
              st_done_q  <= 1'b0;
            end else if (finished_q) begin
              st_done_q <= 1'b1;
              state_q   <= S_EOUT;
            end else if (!started_q) begin
              started_q <= 1'b1;
              for (int i = 0; i < MaxDepth; i++) path_q[i] <= '0;
              if (depth_q == '0 || count_eff != '0) begin
                st_done_q <= 1'b0;
                state_q   <= S_SEED;
              end else begin
                finished_q <= 1'b1;
                st_done_q  <= 1'b1;
                state_q    <= S_EOUT;
              end
            end else begin
              st_done_q <= 1'b0;
              idx_q     <= depth_q;
              state_q   <= S_ADV;
            end
          end
        end
        S_ADV: begin
          if (idx_q == '0) begin
            finished_q <= 1'b1;
            st_done_q  <= 1'b1;
            state_q    <= S_EOUT;
          end else if (adv_p < count_eff) begin
            path_q[4'(idx_q - 4'd1)] <= adv_p[7:0];
            state_q <= S_SEED;
          end else begin
            path_q[4'(idx_q - 4'd1)] <= '0;
            idx_q <= idx_q - 4'd1;
          end
        end
        S_SEED: begin
          if (k_q == 3'(SeedPoints - 1)) begin
            k_q <= '0;
            if (depth_q == '0) begin
              state_q <= S_ERD;
            end else begin
              lv_q    <= 4'd1;
              state_q <= S_RULE;
            end
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_RULE: state_q <= S_PRD;
        S_PRD:  state_q <= S_PMUL;
        S_PMUL: state_q <= S_PWR;
        S_PWR: begin
          if (k_q == 3'(SeedPoints - 1)) begin
            k_q <= '0;
            if (lv_q == depth_q) begin
              state_q <= S_ERD;
            end else begin
              lv_q    <= lv_q + 4'd1;
              state_q <= S_RULE;
            end
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= S_PRD;
          end
        end
        S_ERD:  state_q <= S_EMUL;
        S_EMUL: state_q <= S_ECV;
        S_ECV: begin
          if (half_q) begin
            state_q <= S_EOUT;
          end else begin
            half_q  <= 1'b1;
            state_q <= S_ERD;
          end
        end
        S_EOUT: begin
          if (out_free) begin
            if (st_done_q) begin
              o_xs_q <= '0; o_ys_q <= '0; o_xe_q <= '0; o_ye_q <= '0;
              o_kind_q <= 1'b0;
              o_last_q <= 1'b1;
              o_done_q <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              o_xs_q   <= xs_q;
              o_ys_q   <= ys_q;
              o_xe_q   <= xe_q;
              o_ye_q   <= ye_q;
              o_kind_q <= seg_cnt_q[2];
              o_last_q <= (seg_cnt_q == seg_n - 3'd1);
              o_done_q <= 1'b0;
              half_q   <= 1'b0;
              seg_cnt_q <= seg_cnt_q + 3'd1;
              state_q  <= (seg_cnt_q == seg_n - 3'd1) ? S_IDLE : S_ERD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.x_start      = o_xs_q;
  assign out_o.y_start      = o_ys_q;
  assign out_o.x_end        = o_xe_q;
  assign out_o.y_end        = o_ye_q;
  assign out_o.segment_kind = o_kind_q;
  assign out_o.is_last      = o_last_q;
  assign out_o.done_res     = o_done_q;

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_res |-> out_o.is_last && !out_o.segment_kind)
    else $error("done result without is_last");
  a_fin_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finished_q |-> started_q)
    else $error("walk finished but never started");
  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.op == OpLoad |=> !started_q && !finished_q)
    else $error("load did not restart walk");
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PWR |-> lv_q != '0 && lv_q <= depth_q)
    else $error("level out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(o_xs_q) && $stable(o_last_q))
    else $error("pending result overwritten");

endmodule
